// ===== rtl/core/lrfp_pkg.sv =====
// Shared constants and types for the log record field parser.
`timescale 1ns / 1ps

package lrfp_pkg;

	// Configuration port geometry.
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_EXPECTED_ID = 2'd0;

	// Field widths.
	localparam int CHAR_W   = 8;
	localparam int ID_W     = 16;
	localparam int YEAR_W   = 16;
	localparam int SMALL_W  = 8;
	localparam int STATUS_W = 2;
	localparam int NUM_SMALL = 5;
	localparam int FIELD_CNT = 6;

	localparam logic [ID_W-1:0] EXPECTED_ID_RESET = 16'd1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_STORED    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_CORRUPTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_TIME  = 2'd2;

	// Number scanner phases.
	localparam logic [1:0] PH_SKIP_WS = 2'd0;
	localparam logic [1:0] PH_SIGN    = 2'd1;
	localparam logic [1:0] PH_DIGITS  = 2'd2;
	localparam logic [1:0] PH_DONE    = 2'd3;

	// Characters of interest.
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
	localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
	localparam logic [CHAR_W-1:0] CH_C     = 8'h63;

	// Limits of the counters.
	localparam logic [1:0] SLASH_MAX = 2'd2;
	localparam logic [2:0] COLON_MAX = 3'd5;
	localparam logic [2:0] SECOND_IDX = 3'd5;
	localparam logic [FIELD_CNT-1:0] ALL_FIELDS_OK = 6'h3F;

	typedef logic [CHAR_W-1:0] char_t;

endpackage

// ===== rtl/core/lrfp_if.sv =====
// Valid/ready channel interfaces for the byte input and the parsed result output.
`timescale 1ns / 1ps

interface lrfp_in_if;
	import lrfp_pkg::*;
	logic  valid;
	logic  ready;
	char_t char_in;
	logic  end_of_message;
	modport source(output valid, output char_in, output end_of_message, input ready);
	modport sink(input valid, input char_in, input end_of_message, output ready);
endinterface

interface lrfp_out_if;
	import lrfp_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [YEAR_W-1:0]   year_value;
	logic [SMALL_W-1:0]  month_value;
	logic [SMALL_W-1:0]  day_value;
	logic [SMALL_W-1:0]  hour_value;
	logic [SMALL_W-1:0]  minute_value;
	logic [SMALL_W-1:0]  second_value;
	char_t               event_char;
	modport source(output valid, output status, output year_value, output month_value,
		output day_value, output hour_value, output minute_value, output second_value,
		output event_char, input ready);
	modport sink(input valid, input status, input year_value, input month_value,
		input day_value, input hour_value, input minute_value, input second_value,
		input event_char, output ready);
endinterface

// ===== rtl/core/log_record_field_parser.sv =====
// Streaming parser for id/Y:M:D:h:m:s/E log records with an APB configuration port.
// The byte that ends the message passes through the input register, then the result register.
// One byte per cycle unless a final byte is held; the per-message state is updated from the input register.
// A byte that ends the message waits in the input register only while the result register is full.
// Reset (arst_n low, asynchronous) clears all message state and sets expected_id to 1.
`timescale 1ns / 1ps

module log_record_field_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	lrfp_in_if.sink                       byte_ch,
	lrfp_out_if.source                    result_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lrfp_pkg::PADDR_W-1:0]  paddr,
	input  logic [lrfp_pkg::PDATA_W-1:0]  pwdata,
	output logic [lrfp_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import lrfp_pkg::*;

	// Configuration register.
	logic [ID_W-1:0] expected_id_q;

	// Input register stage.
	logic  valid_s1;
	char_t char_s1;
	logic  last_s1;

	// Per-message state.
	logic [1:0]           slash_q, slash_n;
	logic [2:0]           colon_q, colon_n;
	logic                 ended_q, ended_n;
	logic [1:0]           phase_q, phase_n;
	logic                 neg_q, neg_n;
	logic                 has_digit_q, has_digit_n;
	logic [ID_W-1:0]      value_q, value_n;
	logic                 over_q, over_n;
	logic                 id_match_q, id_match_n;
	logic [YEAR_W-1:0]    year_q, year_n;
	logic [SMALL_W-1:0]   small_q [NUM_SMALL];
	logic [SMALL_W-1:0]   small_n [NUM_SMALL];
	logic [FIELD_CNT-1:0] tf_ok_q, tf_ok_n;
	char_t                event_q, event_n;
	logic                 pending_q, pending_n;

	// Step control and result.
	logic                out_free;
	logic                s1_adv;
	logic                feed;
	logic                commit;
	logic [2:0]          commit_idx;
	logic                commit_ok;
	logic [ID_W-1:0]     commit_val;
	logic                is_digit;
	logic [19:0]         prod;
	char_t               ev;
	logic                ev_ok;
	logic [STATUS_W-1:0] status_n;

	// APB access: always ready, single register at address zero.
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_EXPECTED_ID) ? {{(PDATA_W-ID_W){1'b0}}, expected_id_q}
		: '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q <= EXPECTED_ID_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_EXPECTED_ID)) begin
			expected_id_q <= pwdata[ID_W-1:0];
		end
	end

	// Handshake: the input register advances unless it holds a final byte and the
	// result register cannot take a new result.
	assign out_free      = !result_ch.valid || result_ch.ready;
	assign s1_adv        = valid_s1 && (!last_s1 || out_free);
	assign byte_ch.ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			char_s1 <= byte_ch.char_in;
			last_s1 <= byte_ch.end_of_message;
		end
	end

	// Next state for the byte in the input register.
	always_comb begin
		slash_n     = slash_q;
		colon_n     = colon_q;
		ended_n     = ended_q;
		phase_n     = phase_q;
		neg_n       = neg_q;
		has_digit_n = has_digit_q;
		value_n     = value_q;
		over_n      = over_q;
		id_match_n  = id_match_q;
		year_n      = year_q;
		small_n     = small_q;
		tf_ok_n     = tf_ok_q;
		event_n     = event_q;
		pending_n   = pending_q;
		feed        = 1'b0;
		commit      = 1'b0;
		commit_idx  = SECOND_IDX;

		is_digit   = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
		prod       = ({4'b0, value_q} << 3) + ({4'b0, value_q} << 1) + {16'b0, char_s1[3:0]};
		commit_ok  = has_digit_q && (!neg_q || (value_q == '0));
		commit_val = commit_ok ? value_q : '0;

		// Segment and field splitting.
		if (!ended_q) begin
			if (char_s1 == CH_NUL) begin
				ended_n = 1'b1;
			end else if (char_s1 == CH_SLASH) begin
				if (slash_q == 2'd0) begin
					id_match_n = has_digit_q && !over_q && (!neg_q || (value_q == '0))
						&& (value_q == expected_id_q);
				end else if (slash_q == 2'd1) begin
					commit     = 1'b1;
					commit_idx = SECOND_IDX;
				end
				if (slash_q < SLASH_MAX) begin
					slash_n = slash_q + 2'd1;
				end
				phase_n     = PH_SKIP_WS;
				neg_n       = 1'b0;
				has_digit_n = 1'b0;
				value_n     = '0;
				over_n      = 1'b0;
				event_n     = CH_NUL;
				pending_n   = 1'b1;
			end else begin
				if (pending_q) begin
					event_n   = char_s1;
					pending_n = 1'b0;
				end
				if (slash_q == 2'd0) begin
					feed = 1'b1;
				end else if (slash_q == 2'd1) begin
					if (char_s1 == CH_COLON) begin
						if (colon_q < COLON_MAX) begin
							commit     = 1'b1;
							commit_idx = colon_q;
							colon_n    = colon_q + 3'd1;
						end
						phase_n     = PH_SKIP_WS;
						neg_n       = 1'b0;
						has_digit_n = 1'b0;
						value_n     = '0;
						over_n      = 1'b0;
					end else begin
						feed = 1'b1;
					end
				end
			end
		end

		// Store a finished time field.
		if (commit) begin
			if (commit_idx == 3'd0) begin
				year_n = commit_val;
			end else begin
				small_n[3'(commit_idx - 3'd1)] = (commit_val > 16'd255) ? 8'hFF
					: commit_val[SMALL_W-1:0];
			end
			tf_ok_n[commit_idx] = commit_ok;
		end

		// Number scanner: whitespace, sign, then saturating decimal digits.
		if (feed) begin
			if ((phase_q == PH_SKIP_WS) && (char_s1 inside {8'h20, [8'h09:8'h0D]})) begin
				phase_n = PH_SKIP_WS;
			end else if ((phase_q == PH_SKIP_WS) &&
					((char_s1 == CH_PLUS) || (char_s1 == CH_MINUS))) begin
				neg_n   = (char_s1 == CH_MINUS);
				phase_n = PH_SIGN;
			end else if (phase_q == PH_DONE) begin
				phase_n = PH_DONE;
			end else if (!is_digit) begin
				phase_n = PH_DONE;
			end else begin
				phase_n     = PH_DIGITS;
				has_digit_n = 1'b1;
				if (prod > 20'hFFFF) begin
					value_n = 16'hFFFF;
					over_n  = 1'b1;
				end else begin
					value_n = prod[ID_W-1:0];
				end
			end
		end

		// Result status from the state after this byte.
		ev    = (slash_n != 2'd0) ? event_n : CH_NUL;
		ev_ok = (ev == CH_A) || (ev == CH_B) || (ev == CH_C);
		if (!id_match_n || !ev_ok) begin
			status_n = STATUS_CORRUPTED;
		end else if (tf_ok_n != ALL_FIELDS_OK) begin
			status_n = STATUS_BAD_TIME;
		end else begin
			status_n = STATUS_STORED;
		end
	end

	// Message state update; the final byte of a message clears everything.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slash_q     <= '0;
			colon_q     <= '0;
			ended_q     <= 1'b0;
			phase_q     <= PH_SKIP_WS;
			neg_q       <= 1'b0;
			has_digit_q <= 1'b0;
			value_q     <= '0;
			over_q      <= 1'b0;
			id_match_q  <= 1'b0;
			year_q      <= '0;
			small_q     <= '{default: '0};
			tf_ok_q     <= '0;
			event_q     <= CH_NUL;
			pending_q   <= 1'b0;
		end else if (s1_adv) begin
			if (last_s1) begin
				slash_q     <= '0;
				colon_q     <= '0;
				ended_q     <= 1'b0;
				phase_q     <= PH_SKIP_WS;
				neg_q       <= 1'b0;
				has_digit_q <= 1'b0;
				value_q     <= '0;
				over_q      <= 1'b0;
				id_match_q  <= 1'b0;
				year_q      <= '0;
				small_q     <= '{default: '0};
				tf_ok_q     <= '0;
				event_q     <= CH_NUL;
				pending_q   <= 1'b0;
			end else begin
				slash_q     <= slash_n;
				colon_q     <= colon_n;
				ended_q     <= ended_n;
				phase_q     <= phase_n;
				neg_q       <= neg_n;
				has_digit_q <= has_digit_n;
				value_q     <= value_n;
				over_q      <= over_n;
				id_match_q  <= id_match_n;
				year_q      <= year_n;
				small_q     <= small_n;
				tf_ok_q     <= tf_ok_n;
				event_q     <= event_n;
				pending_q   <= pending_n;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.valid <= 1'b0;
		end else if (out_free) begin
			result_ch.valid <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && last_s1) begin
			result_ch.status       <= status_n;
			result_ch.year_value   <= year_n;
			result_ch.month_value  <= small_n[0];
			result_ch.day_value    <= small_n[1];
			result_ch.hour_value   <= small_n[2];
			result_ch.minute_value <= small_n[3];
			result_ch.second_value <= small_n[4];
			result_ch.event_char   <= ev;
		end
	end

	// A new result appears only after a final byte left the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_ch.valid) |-> $past(valid_s1 && last_s1))
		else $error("result without a final byte");

	// A stored message always carries a valid event character.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && (result_ch.status == STATUS_STORED)) |->
		((result_ch.event_char == CH_A) || (result_ch.event_char == CH_B) ||
		(result_ch.event_char == CH_C)))
		else $error("stored status with a bad event character");

	// The segment and field counters stay within their saturation limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(slash_q <= SLASH_MAX) && (colon_q <= COLON_MAX))
		else $error("separator counter out of range");

	// A stalled final byte keeps the input register occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && !out_free) |=> valid_s1)
		else $error("final byte lost while the result register was full");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the log record field parser: directed and random messages.
`timescale 1ns / 1ps

module tb_top;
	import lrfp_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASE_BYTES = 225;
	localparam int TAIL_CYCLES = 8;
	localparam int NUM_PHASES = 6;

	// One parsed record as it leaves the block.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [YEAR_W-1:0]   year_value;
		logic [SMALL_W-1:0]  month_value;
		logic [SMALL_W-1:0]  day_value;
		logic [SMALL_W-1:0]  hour_value;
		logic [SMALL_W-1:0]  minute_value;
		logic [SMALL_W-1:0]  second_value;
		char_t               event_char;
	} record_t;

	// Tracks the parse of each message and holds the records still to arrive.
	class record_scoreboard;
		localparam int MAX_PRINTS = 100;

		logic [ID_W-1:0]      want_id;
		logic [1:0]           slash_seen;
		logic [2:0]           colon_seen;
		bit                   text_stopped;
		logic [1:0]           scan_phase;
		bit                   scan_neg;
		bit                   scan_digit;
		logic [15:0]          scan_val;
		bit                   scan_sat;
		bit                   id_ok;
		logic [YEAR_W-1:0]    year_q;
		logic [SMALL_W-1:0]   small_q [NUM_SMALL];
		logic [FIELD_CNT-1:0] field_good;
		char_t                event_q;
		bit                   event_armed;
		record_t              expected_records [$];
		int                   errors;

		function new();
			want_id = EXPECTED_ID_RESET;
			errors = 0;
			clear_message();
		endfunction

		function void clear_number();
			scan_phase = PH_SKIP_WS;
			scan_neg = 1'b0;
			scan_digit = 1'b0;
			scan_val = '0;
			scan_sat = 1'b0;
		endfunction

		function void clear_message();
			slash_seen = '0;
			colon_seen = '0;
			text_stopped = 1'b0;
			clear_number();
			id_ok = 1'b0;
			year_q = '0;
			foreach (small_q[i]) small_q[i] = '0;
			field_good = '0;
			event_q = CH_NUL;
			event_armed = 1'b0;
		endfunction

		// Number scan in the manner of a library string-to-int, saturating at 16 bits.
		function void scan_char(char_t c);
			bit          dig;
			bit          blank;
			logic [31:0] acc;
			dig = (c >= CH_ZERO) && (c <= CH_NINE);
			blank = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
			if (scan_phase == PH_SKIP_WS) begin
				if (blank)
					return;
				if ((c == CH_PLUS) || (c == CH_MINUS)) begin
					scan_neg = (c == CH_MINUS);
					scan_phase = PH_SIGN;
					return;
				end
			end
			if (scan_phase == PH_DONE)
				return;
			if (!dig) begin
				scan_phase = PH_DONE;
				return;
			end
			scan_phase = PH_DIGITS;
			scan_digit = 1'b1;
			acc = {16'd0, scan_val} * 32'd10 + {24'd0, c} - {24'd0, CH_ZERO};
			if (acc > 32'd65535) begin
				acc = 32'd65535;
				scan_sat = 1'b1;
			end
			scan_val = acc[15:0];
		endfunction

		// Store the finished number as clock field idx, 0 for the year up to 5 for seconds.
		function void commit_field(int idx);
			bit          ok;
			logic [15:0] v;
			ok = scan_digit && (!scan_neg || (scan_val == 16'd0));
			v = ok ? scan_val : 16'd0;
			if (idx == 0)
				year_q = v;
			else if (idx <= NUM_SMALL)
				small_q[idx-1] = (v > 16'd255) ? 8'hFF : v[7:0];
			else
				return;
			field_good[idx] = ok;
		endfunction

		// Segment and field splitting of one byte of text.
		function void split_char(char_t c);
			if (c == CH_SLASH) begin
				if (slash_seen == 2'd0)
					id_ok = scan_digit && !scan_sat && (!scan_neg || (scan_val == 16'd0)) &&
						(scan_val == want_id);
				else if (slash_seen == 2'd1)
					commit_field(int'(SECOND_IDX));
				if (slash_seen < SLASH_MAX)
					slash_seen++;
				clear_number();
				event_q = CH_NUL;
				event_armed = 1'b1;
				return;
			end
			if (event_armed) begin
				event_q = c;
				event_armed = 1'b0;
			end
			if (slash_seen == 2'd0) begin
				scan_char(c);
			end else if (slash_seen == 2'd1) begin
				if (c == CH_COLON) begin
					if (colon_seen < COLON_MAX) begin
						commit_field(int'(colon_seen));
						colon_seen++;
					end
					clear_number();
				end else begin
					scan_char(c);
				end
			end
		endfunction

		// Called for every byte transfer; a message end queues the record it must produce.
		function void parse_byte(char_t c, logic last);
			record_t rec;
			char_t   ev;
			bit      ev_ok;
			if (!text_stopped) begin
				if (c == CH_NUL)
					text_stopped = 1'b1;
				else
					split_char(c);
			end
			if (!last)
				return;
			ev = (slash_seen != 2'd0) ? event_q : CH_NUL;
			ev_ok = (ev == CH_A) || (ev == CH_B) || (ev == CH_C);
			if (!id_ok || !ev_ok)
				rec.status = STATUS_CORRUPTED;
			else if (field_good != ALL_FIELDS_OK)
				rec.status = STATUS_BAD_TIME;
			else
				rec.status = STATUS_STORED;
			rec.year_value = year_q;
			rec.month_value = small_q[0];
			rec.day_value = small_q[1];
			rec.hour_value = small_q[2];
			rec.minute_value = small_q[3];
			rec.second_value = small_q[4];
			rec.event_char = ev;
			expected_records.push_back(rec);
			clear_message();
		endfunction

		// One line per mismatch; printing stops after a while but counting does not.
		function void report(string what, int got, int want_v);
			if (errors < MAX_PRINTS)
				$display("mismatch %s: got %0d, expected %0d", what, got, want_v);
			errors++;
		endfunction

		function void check_record(record_t got);
			record_t want;
			if (expected_records.size() == 0) begin
				report("record with none outstanding, status", got.status, -1);
				return;
			end
			want = expected_records.pop_front();
			if (got.status !== want.status)
				report("status", got.status, want.status);
			if (got.year_value !== want.year_value)
				report("year_value", got.year_value, want.year_value);
			if (got.month_value !== want.month_value)
				report("month_value", got.month_value, want.month_value);
			if (got.day_value !== want.day_value)
				report("day_value", got.day_value, want.day_value);
			if (got.hour_value !== want.hour_value)
				report("hour_value", got.hour_value, want.hour_value);
			if (got.minute_value !== want.minute_value)
				report("minute_value", got.minute_value, want.minute_value);
			if (got.second_value !== want.second_value)
				report("second_value", got.second_value, want.second_value);
			if (got.event_char !== want.event_char)
				report("event_char", got.event_char, want.event_char);
		endfunction

		function int pending();
			return expected_records.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	lrfp_in_if  byte_if ();
	lrfp_out_if result_if ();

	record_scoreboard sb;
	char_t            msg_bytes [$];
	bit               idle_on;
	bit               sink_idle;
	int               stall_left;
	int               cycle_count;
	int               sent_bytes;

	log_record_field_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_if),
		.result_ch (result_if),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Byte transfers feed the parse model.
	always @(posedge clk) begin
		if (arst_n && byte_if.valid && byte_if.ready)
			sb.parse_byte(byte_if.char_in, byte_if.end_of_message);
	end

	// Result transfers are checked against the oldest outstanding record.
	always @(posedge clk) begin
		record_t got;
		if (arst_n && result_if.valid && result_if.ready) begin
			got.status = result_if.status;
			got.year_value = result_if.year_value;
			got.month_value = result_if.month_value;
			got.day_value = result_if.day_value;
			got.hour_value = result_if.hour_value;
			got.minute_value = result_if.minute_value;
			got.second_value = result_if.second_value;
			got.event_char = result_if.event_char;
			sb.check_record(got);
		end
	end

	// Result side back-pressure in bursts, with quiet stretches in between.
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0)
			sink_idle <= ~sink_idle;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && sink_idle && ($urandom_range(0, 5) == 0)) begin
			result_if.ready <= 1'b0;
			stall_left <= $urandom_range(0, 16);
		end else begin
			result_if.ready <= 1'b1;
		end
	end

	// Run limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Starts and ends at a falling edge; an optional gap with valid low comes first.
	task automatic drive_byte(input char_t c, input logic last, input bit gappy);
		if (gappy && ($urandom_range(0, 5) == 0)) begin
			byte_if.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.char_in <= c;
		byte_if.end_of_message <= last;
		do @(posedge clk); while (!(byte_if.valid && byte_if.ready));
		@(negedge clk);
	endtask

	task automatic send_message();
		bit gappy;
		gappy = idle_on && ($urandom_range(0, 2) != 0);
		for (int i = 0; i < msg_bytes.size(); i++)
			drive_byte(msg_bytes[i], i == msg_bytes.size() - 1, gappy);
		sent_bytes += msg_bytes.size();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_bytes.push_back(s[i]);
	endtask

	task automatic add_number(input int unsigned top);
		add_text($sformatf("%0d", $urandom_range(0, top)));
	endtask

	task automatic send_text(input string s);
		msg_bytes.delete();
		add_text(s);
		send_message();
	endtask

	// One number token: mostly clean, with blanks, signs, overflow and junk mixed in.
	task automatic add_field(input int unsigned top);
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			add_number(top);
		end else if (r < 62) begin
			add_text($sformatf("%0d", $urandom));
		end else if (r < 67) begin
			n = $urandom_range(0, 4);
			case (n)
				0: add_text("255");
				1: add_text("256");
				2: add_text("65535");
				3: add_text("65536");
				default: add_text("007");
			endcase
		end else if (r < 72) begin
			n = $urandom_range(1, 3);
			repeat (n)
				msg_bytes.push_back(($urandom_range(0, 5) == 0) ? 8'h20 :
					char_t'(8'h09 + $urandom_range(0, 4)));
			add_number(top);
		end else if (r < 77) begin
			msg_bytes.push_back(CH_PLUS);
			add_number(top);
		end else if (r < 81) begin
			add_text(($urandom_range(0, 1) == 0) ? "-0" : "-000");
		end else if (r < 86) begin
			msg_bytes.push_back(CH_MINUS);
			add_number(top + 1);
		end else if (r < 89) begin
			// Empty token.
		end else if (r < 91) begin
			msg_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_PLUS : CH_MINUS);
		end else if (r < 95) begin
			msg_bytes.push_back(char_t'(8'h41 + $urandom_range(0, 25)));
			add_number(top);
		end else begin
			add_number(top);
			msg_bytes.push_back(char_t'(8'h61 + $urandom_range(0, 25)));
			add_number(9);
		end
	endtask

	// A record that is mostly well formed, with broken structure now and then.
	task automatic build_message(input logic [ID_W-1:0] want);
		int r;
		int shape;
		int colons;
		int extra;
		msg_bytes.delete();
		r = $urandom_range(0, 99);
		if (r < 70) begin
			if ($urandom_range(0, 4) == 0)
				msg_bytes.push_back(8'h20);
			if ($urandom_range(0, 5) == 0)
				msg_bytes.push_back(CH_PLUS);
			add_text($sformatf("%0d", want));
		end else if (r < 76) begin
			add_text((want == '0) ? "-0" : "-1");
		end else if (r < 84) begin
			add_number(65535);
		end else if (r < 88) begin
			add_text("65536");
		end else begin
			add_field(65535);
		end
		shape = $urandom_range(0, 99);
		if (shape >= 3) begin
			msg_bytes.push_back(CH_SLASH);
			if (shape >= 7) begin
				colons = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : 5;
				add_field(3000);
				for (int k = 0; k < colons; k++) begin
					msg_bytes.push_back(CH_COLON);
					add_field(59);
				end
				if (shape >= 12) begin
					msg_bytes.push_back(CH_SLASH);
					if ($urandom_range(0, 99) < 85)
						msg_bytes.push_back(char_t'(CH_A + $urandom_range(0, 2)));
					else
						msg_bytes.push_back(char_t'($urandom_range(1, 255)));
					if ($urandom_range(0, 99) < 15) begin
						extra = $urandom_range(1, 5);
						repeat (extra)
							msg_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_SLASH :
								char_t'($urandom_range(1, 255)));
					end
				end
			end
		end
		if (msg_bytes.size() == 0)
			msg_bytes.push_back(char_t'($urandom_range(1, 255)));
		// A zero byte cuts the text short.
		if ($urandom_range(0, 99) < 4)
			msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = CH_NUL;
	endtask

	// Short bursts of arbitrary bytes, rich in separators.
	task automatic build_noise();
		int n;
		int r;
		msg_bytes.delete();
		n = $urandom_range(1, 12);
		repeat (n) begin
			r = $urandom_range(0, 9);
			if (r < 5)
				msg_bytes.push_back(char_t'($urandom_range(0, 255)));
			else if (r < 6)
				msg_bytes.push_back(CH_SLASH);
			else if (r < 7)
				msg_bytes.push_back(CH_COLON);
			else if (r < 9)
				msg_bytes.push_back(char_t'(CH_ZERO + $urandom_range(0, 9)));
			else
				msg_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_MINUS : 8'h20);
		end
	endtask

	// Waits for every outstanding record, then lets the pipeline settle.
	task automatic wait_drained();
		byte_if.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// Register write on the configuration port: a setup phase, then an access phase.
	task automatic write_expected_id(input logic [ID_W-1:0] v);
		logic [15:0] upper;
		upper = 16'($urandom_range(0, 65535));
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_EXPECTED_ID;
		pwdata <= {upper, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.want_id = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		logic [ID_W-1:0] id_plan [NUM_PHASES];
		int phase_start;
		sb = new();
		idle_on = 1'b1;
		sink_idle = 1'b1;
		stall_left = 0;
		sent_bytes = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_if.valid = 1'b0;
		byte_if.char_in = '0;
		byte_if.end_of_message = 1'b0;
		result_if.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: a clean record, a single slash, no slash, a zero byte.
		send_text("1/0:0:0:0:0:0/a");
		send_text("1/");
		send_text("7");
		msg_bytes.delete();
		msg_bytes.push_back(CH_NUL);
		send_message();
		wait_drained();
		// Directed: a negative zero id.
		write_expected_id(16'd0);
		send_text("-0/");
		wait_drained();

		// Random phases under several ids, the extremes among them.
		id_plan[0] = 16'hFFFF;
		id_plan[1] = 16'($urandom_range(2, 65534));
		id_plan[2] = 16'd0;
		id_plan[3] = 16'd1;
		id_plan[4] = 16'($urandom_range(0, 99));
		id_plan[5] = 16'd12;
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == NUM_PHASES - 1)
				idle_on = 1'b0;
			write_expected_id(id_plan[p]);
			phase_start = sent_bytes;
			while (sent_bytes - phase_start < PHASE_BYTES) begin
				if ($urandom_range(0, 9) == 0)
					build_noise();
				else
					build_message(id_plan[p]);
				send_message();
			end
			wait_drained();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
